FILE: sv/amu_pkg.sv
// Shared constants, stage types and iteration steps for the Adam moment update block.
// Used by every module of the block except amu_ram; depends on nothing.
`default_nettype none
package amu_pkg;

    localparam int STORE_DEPTH = 4096;             // power of two
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = 12;
    localparam int GRAD_W      = 32;
    localparam int M_W         = 32;
    localparam int V_W         = 48;
    localparam int DEC_W       = 16;
    localparam int WORD_W      = 32;
    localparam int IN_DATA_W   = 48;               // gradient + index, padded to bytes
    localparam int CFG_ADDR_W  = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_DECAY  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_DECAY = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_EPSILON      = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SCALE   = CFG_ADDR_W'(3);

    localparam logic [DEC_W-1:0]  RST_FIRST_DECAY  = 16'd58982;
    localparam logic [DEC_W-1:0]  RST_SECOND_DECAY = 16'd65470;
    localparam logic [WORD_W-1:0] RST_EPSILON      = 32'd1;
    localparam logic [WORD_W-1:0] RST_STEP_SCALE   = 32'd66;

    localparam logic [DEC_W:0]    ONE_Q16  = 17'd65536;
    localparam logic [DEC_W-1:0]  HALF_Q16 = 16'd32768;
    localparam logic [WORD_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_MIN  = 32'h8000_0000;

    // root of a 64-bit radicand: one bit per step
    localparam int SQ_BITS   = 32;
    localparam int SQ_PER    = 2;
    localparam int SQ_STAGES = SQ_BITS / SQ_PER;
    // quotient below 2^33 after the overflow check
    localparam int DV_BITS   = 33;
    localparam int DV_PER    = 3;
    localparam int DV_STAGES = DV_BITS / DV_PER;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sq;

    typedef struct packed {
        logic [33:0] rem;
        logic [63:0] num;
        logic [32:0] quo;
    } t_dv;

    typedef struct packed {
        logic neg;
        logic mzero;
        logic dzero;
        logic ovf;
    } t_dflag;

    function automatic t_sq sq_step(input t_sq s);
        t_sq         r;
        logic [34:0] rem2;
        logic [34:0] trial;
        rem2  = {s.rem[32:0], s.rad[63:62]};
        trial = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[61:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem  = rem2 - trial;
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = rem2;
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input logic [32:0] den);
        t_dv         r;
        logic [33:0] rem2;
        rem2  = {s.rem[32:0], s.num[63]};
        r.num = {s.num[62:0], 1'b0};
        if (rem2 >= {1'b0, den}) begin
            r.rem = rem2 - {1'b0, den};
            r.quo = {s.quo[31:0], 1'b1};
        end else begin
            r.rem = rem2;
            r.quo = {s.quo[31:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/amu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module amu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: sv/amu_moment.sv
// Moment stage: store read, forwarding, first/second moment update and write-back.
// Depends on amu_pkg and amu_ram.
`default_nettype none
module amu_moment (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_valid,
    input  wire logic signed [amu_pkg::GRAD_W-1:0] i_grad,
    input  wire logic [amu_pkg::IDX_W-1:0]     i_idx,
    input  wire logic [amu_pkg::DEC_W-1:0]     i_b1,
    input  wire logic [amu_pkg::DEC_W-1:0]     i_b2,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic signed [amu_pkg::M_W-1:0]     o_m,
    output logic [amu_pkg::V_W-1:0]            o_v
);
    import amu_pkg::*;

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic                     r_s1_valid;
    logic signed [GRAD_W-1:0] r_s1_g;
    logic [ADDR_W-1:0]        r_s1_idx;

    logic                     r_s2_valid;
    logic signed [GRAD_W-1:0] r_s2_g;
    logic [ADDR_W-1:0]        r_s2_idx;
    logic [V_W-1:0]           r_s2_gsq;

    logic                  r_s3_valid;
    logic [ADDR_W-1:0]     r_s3_idx;
    logic signed [M_W-1:0] r_s3_m;
    logic [V_W-1:0]        r_s3_v;

    logic                  r_s4_valid;
    logic [ADDR_W-1:0]     r_s4_idx;
    logic signed [M_W-1:0] r_s4_m;
    logic [V_W-1:0]        r_s4_v;

    logic [GRAD_W-1:0]      w_gabs;
    logic [2*GRAD_W-1:0]    w_gsq_full;
    logic [V_W+M_W-1:0]     w_rdata;
    logic signed [M_W-1:0]  w_m_old;
    logic [V_W-1:0]         w_v_old;
    logic signed [17:0]     w_nb1;
    logic signed [17:0]     w_b1;
    logic signed [49:0]     w_p1;
    logic signed [49:0]     w_p2;
    logic signed [50:0]     w_msum;
    logic [64:0]            w_vsum;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [V_W+M_W-1:0]     w_wdata;

    // clearing pass over the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign w_gabs     = r_s1_g[GRAD_W-1] ? GRAD_W'(-r_s1_g) : GRAD_W'(r_s1_g);
    assign w_gsq_full = 64'(w_gabs) * 64'(w_gabs) + 64'(HALF_Q16);

    // newest value first: one stage ahead is unwritten, two ahead wrote on the read edge
    always_comb begin
        if (r_s3_valid && (r_s3_idx == r_s2_idx)) begin
            w_m_old = r_s3_m;
            w_v_old = r_s3_v;
        end else if (r_s4_valid && (r_s4_idx == r_s2_idx)) begin
            w_m_old = r_s4_m;
            w_v_old = r_s4_v;
        end else begin
            w_m_old = signed'(w_rdata[M_W-1:0]);
            w_v_old = w_rdata[V_W+M_W-1:M_W];
        end
    end

    assign w_nb1  = signed'({1'b0, ONE_Q16 - {1'b0, i_b1}});
    assign w_b1   = signed'({2'b00, i_b1});
    assign w_p1   = w_nb1 * r_s2_g;
    assign w_p2   = w_b1 * w_m_old;
    assign w_msum = 51'(w_p1) + 51'(w_p2) + 51'(signed'({1'b0, HALF_Q16}));
    assign w_vsum = 65'(ONE_Q16 - {1'b0, i_b2}) * 65'(r_s2_gsq)
                  + 65'(i_b2) * 65'(w_v_old) + 65'(HALF_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_g   <= i_grad;
            r_s1_idx <= i_idx[ADDR_W-1:0];
            r_s2_g   <= r_s1_g;
            r_s2_idx <= r_s1_idx;
            r_s2_gsq <= w_gsq_full[V_W+15:16];
            r_s3_idx <= r_s2_idx;
            r_s3_m   <= w_msum[M_W+15:16];
            r_s3_v   <= w_vsum[V_W+15:16];
            r_s4_idx <= r_s3_idx;
            r_s4_m   <= r_s3_m;
            r_s4_v   <= r_s3_v;
        end
    end

    assign w_we    = r_clr_busy || (r_s3_valid && i_adv);
    assign w_waddr = r_clr_busy ? r_clr_addr : r_s3_idx;
    assign w_wdata = r_clr_busy ? '0 : {r_s3_v, r_s3_m};

    amu_ram #(
        .WIDTH (V_W + M_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_adv),
        .i_raddr (r_s1_idx),
        .o_rdata (w_rdata)
    );

    assign o_busy  = r_clr_busy;
    assign o_valid = r_s3_valid;
    assign o_m     = r_s3_m;
    assign o_v     = r_s3_v;
endmodule
`default_nettype wire

FILE: sv/amu_sqrt.sv
// Pipelined integer square root of the second moment in Q16.16, two root bits per stage.
// Depends on amu_pkg.
`default_nettype none
module amu_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_valid,
    input  wire logic signed [amu_pkg::M_W-1:0] i_m,
    input  wire logic [amu_pkg::V_W-1:0]       i_v,
    output logic                               o_valid,
    output logic signed [amu_pkg::M_W-1:0]     o_m,
    output logic [31:0]                        o_root
);
    import amu_pkg::*;

    logic                  r_valid [SQ_STAGES];
    logic signed [M_W-1:0] r_m     [SQ_STAGES];
    t_sq                   r_sq    [SQ_STAGES];
    t_sq                   n_sq    [SQ_STAGES];
    t_sq                   w_in    [SQ_STAGES];

    always_comb begin
        t_sq s;
        w_in[0].rem  = '0;
        w_in[0].root = '0;
        w_in[0].rad  = {i_v, 16'h0000};
        for (int k = 1; k < SQ_STAGES; k++) begin
            w_in[k] = r_sq[k-1];
        end
        for (int k = 0; k < SQ_STAGES; k++) begin
            s = w_in[k];
            for (int j = 0; j < SQ_PER; j++) begin
                s = sq_step(s);
            end
            n_sq[k] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m[0] <= i_m;
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_m[k] <= r_m[k-1];
            end
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    assign o_valid = r_valid[SQ_STAGES-1];
    assign o_m     = r_m[SQ_STAGES-1];
    assign o_root  = r_sq[SQ_STAGES-1].root;
endmodule
`default_nettype wire

FILE: sv/amu_div.sv
// Scaling, pipelined rounded division by (root + epsilon), saturation and output register.
// Depends on amu_pkg.
`default_nettype none
module amu_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_adv,
    input  wire logic                           i_valid,
    input  wire logic signed [amu_pkg::M_W-1:0] i_m,
    input  wire logic [31:0]                    i_root,
    input  wire logic [amu_pkg::WORD_W-1:0]     i_eps,
    input  wire logic [amu_pkg::WORD_W-1:0]     i_scale,
    output logic                                o_valid,
    output logic [amu_pkg::WORD_W-1:0]          o_data,
    output logic                                o_sat
);
    import amu_pkg::*;

    logic         r_d0_valid;
    logic         r_d0_neg;
    logic         r_d0_mzero;
    logic [32:0]  r_d0_den;
    logic [63:0]  r_d0_prod;

    logic         r_d1_valid;
    t_dflag       r_d1_fl;
    logic [32:0]  r_d1_den;
    t_dv          r_d1_dv;

    logic         r_valid [DV_STAGES];
    t_dflag       r_fl    [DV_STAGES];
    logic [32:0]  r_den   [DV_STAGES];
    t_dv          r_dv    [DV_STAGES];
    t_dv          n_dv    [DV_STAGES];

    logic         r_out_valid;
    logic [WORD_W-1:0] r_out_data;
    logic         r_out_sat;

    logic [M_W-1:0] w_mabs;
    logic [63:0]    w_num;
    t_dflag         w_fl;
    t_dv            w_init;
    t_dflag         w_last_fl;
    logic [32:0]    w_q;
    logic [WORD_W-1:0] n_out_data;
    logic           n_out_sat;

    assign w_mabs = i_m[M_W-1] ? M_W'(-i_m) : M_W'(i_m);
    assign w_num  = r_d0_prod + 64'(r_d0_den[32:1]);

    always_comb begin
        w_fl.neg    = r_d0_neg;
        w_fl.mzero  = r_d0_mzero;
        w_fl.dzero  = (r_d0_den == '0);
        w_fl.ovf    = ({2'b00, w_num[63:33]} >= r_d0_den);
        w_init.rem  = {3'b000, w_num[63:33]};
        w_init.num  = {w_num[32:0], 31'h0};
        w_init.quo  = '0;
    end

    always_comb begin
        t_dv s;
        for (int k = 0; k < DV_STAGES; k++) begin
            s = (k == 0) ? r_d1_dv : r_dv[(k == 0) ? 0 : k-1];
            for (int j = 0; j < DV_PER; j++) begin
                s = dv_step(s, (k == 0) ? r_d1_den : r_den[(k == 0) ? 0 : k-1]);
            end
            n_dv[k] = s;
        end
    end

    assign w_last_fl = r_fl[DV_STAGES-1];
    assign w_q       = r_dv[DV_STAGES-1].quo;

    // zero divisor, quotient overflow and the two clip limits
    always_comb begin
        n_out_sat  = 1'b0;
        n_out_data = '0;
        if (w_last_fl.dzero) begin
            if (!w_last_fl.mzero) begin
                n_out_sat  = 1'b1;
                n_out_data = w_last_fl.neg ? NEG_MIN : POS_MAX;
            end
        end else if (w_last_fl.ovf) begin
            n_out_sat  = 1'b1;
            n_out_data = w_last_fl.neg ? NEG_MIN : POS_MAX;
        end else if (!w_last_fl.neg) begin
            if (w_q > {1'b0, POS_MAX}) begin
                n_out_sat  = 1'b1;
                n_out_data = POS_MAX;
            end else begin
                n_out_data = w_q[WORD_W-1:0];
            end
        end else begin
            if (w_q > {1'b0, NEG_MIN}) begin
                n_out_sat  = 1'b1;
                n_out_data = NEG_MIN;
            end else begin
                n_out_data = ~w_q[WORD_W-1:0] + WORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_valid  <= 1'b0;
            r_d1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < DV_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_d0_valid <= i_valid;
            r_d1_valid <= r_d0_valid;
            r_valid[0] <= r_d1_valid;
            for (int k = 1; k < DV_STAGES; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            r_out_valid <= r_valid[DV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d0_neg   <= i_m[M_W-1];
            r_d0_mzero <= (i_m == '0);
            r_d0_den   <= 33'(i_root) + 33'(i_eps);
            r_d0_prod  <= 64'(i_scale) * 64'(w_mabs);
            r_d1_fl    <= w_fl;
            r_d1_den   <= r_d0_den;
            r_d1_dv    <= w_init;
            r_fl[0]    <= r_d1_fl;
            r_den[0]   <= r_d1_den;
            for (int k = 1; k < DV_STAGES; k++) begin
                r_fl[k]  <= r_fl[k-1];
                r_den[k] <= r_den[k-1];
            end
            for (int k = 0; k < DV_STAGES; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_out_data <= n_out_data;
            r_out_sat  <= n_out_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_sat   = r_out_sat;
endmodule
`default_nettype wire

FILE: sv/adam_moment_update.sv
// Adam moment update: one gradient element in, one scaled update out per beat.
// Channels: slave stream takes {element_index, gradient}; master stream returns the
// update in tdata and the clip flag in tuser; a write channel sets the four registers.
// Each element reads and rewrites its own first and second moment entry; back-to-back
// beats to the same element are forwarded from the pipeline, so any index order runs
// at full rate.
// Throughput: one beat per cycle while the output is not stalled. Pipeline: 3 moment
// stages, 16 root stages, 2 scale stages, 11 divide stages and an output register lie
// between the input beat and its result. The root and divide pipelines set that depth.
// Reset: registers return to their defaults, then a clearing pass zeroes both moments
// in all 4096 entries of the shared store, one entry per cycle; s_axis_tready stays low meanwhile.
// Register writes are taken in any cycle.
// Stall: while a result waits with m_axis_tready low, the whole pipeline holds and
// s_axis_tready drops; nothing is lost or repeated.
// Depends on amu_pkg, amu_moment, amu_sqrt, amu_div, amu_ram.
`default_nettype none
module adam_moment_update (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [31:0] gradient, [43:32] element_index, [47:44] zero
    input  wire logic [amu_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [31:0] update_value
    output logic [amu_pkg::WORD_W-1:0]             o_m_axis_tdata,
    // [0] saturated
    output logic                                   o_m_axis_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [amu_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [amu_pkg::WORD_W-1:0]        i_cfg_data
);
    import amu_pkg::*;

    logic [DEC_W-1:0]  r_first_decay;
    logic [DEC_W-1:0]  r_second_decay;
    logic [WORD_W-1:0] r_epsilon;
    logic [WORD_W-1:0] r_step_scale;

    logic                  w_adv;
    logic                  w_busy;
    logic                  w_in_valid;
    logic                  w_mo_valid;
    logic signed [M_W-1:0] w_mo_m;
    logic [V_W-1:0]        w_mo_v;
    logic                  w_sq_valid;
    logic signed [M_W-1:0] w_sq_m;
    logic [31:0]           w_sq_root;
    logic                  w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_decay  <= RST_FIRST_DECAY;
            r_second_decay <= RST_SECOND_DECAY;
            r_epsilon      <= RST_EPSILON;
            r_step_scale   <= RST_STEP_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_FIRST_DECAY:  r_first_decay  <= i_cfg_data[DEC_W-1:0];
                REG_SECOND_DECAY: r_second_decay <= i_cfg_data[DEC_W-1:0];
                REG_EPSILON:      r_epsilon      <= i_cfg_data;
                REG_STEP_SCALE:   r_step_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance everything unless a result is waiting on the output
    assign w_adv           = !w_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv && !w_busy;
    assign w_in_valid      = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = w_out_valid;

    amu_moment u_moment (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_in_valid),
        .i_grad  (signed'(i_s_axis_tdata[GRAD_W-1:0])),
        .i_idx   (i_s_axis_tdata[GRAD_W+IDX_W-1:GRAD_W]),
        .i_b1    (r_first_decay),
        .i_b2    (r_second_decay),
        .o_busy  (w_busy),
        .o_valid (w_mo_valid),
        .o_m     (w_mo_m),
        .o_v     (w_mo_v)
    );

    amu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_mo_valid),
        .i_m     (w_mo_m),
        .i_v     (w_mo_v),
        .o_valid (w_sq_valid),
        .o_m     (w_sq_m),
        .o_root  (w_sq_root)
    );

    amu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sq_valid),
        .i_m     (w_sq_m),
        .i_root  (w_sq_root),
        .i_eps   (r_epsilon),
        .i_scale (r_step_scale),
        .o_valid (w_out_valid),
        .o_data  (o_m_axis_tdata),
        .o_sat   (o_m_axis_tuser)
    );
endmodule
`default_nettype wire

FILE: sv/amu_checker.sv
// Port-level checks for the Adam moment update block, bound to its top level.
// Depends on amu_pkg and adam_moment_update.
`default_nettype none
module amu_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_axis_tvalid,
    input wire logic                              o_s_axis_tready,
    input wire logic [amu_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [amu_pkg::WORD_W-1:0]        o_m_axis_tdata,
    input wire logic                              o_m_axis_tuser,
    input wire logic                              i_cfg_valid,
    input wire logic                              o_cfg_ready,
    input wire logic [amu_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input wire logic [amu_pkg::WORD_W-1:0]        i_cfg_data
);
    import amu_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid right after reset");

    a_clear_blocks_input: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_s_axis_tready)
        else $error("input taken before the store clearing pass");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output beat changed");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while the pipeline is held");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (o_m_axis_tdata == POS_MAX) || (o_m_axis_tdata == NEG_MIN))
        else $error("clip flag set on a value off the limits");
endmodule

bind adam_moment_update amu_checker u_amu_checker (.*);
`default_nettype wire
